// ===== rtl/core/dotq_pkg.sv =====
package dotq_pkg;

   localparam int QUEUE_DEPTH = 64;
   localparam int TIME_BITS   = 48;
   localparam int HANDLE_BITS = 16;
   localparam int CLASS_BITS  = 16;
   localparam int IDX_BITS    = $clog2(QUEUE_DEPTH);
   localparam int CNT_BITS    = $clog2(QUEUE_DEPTH + 1);

   localparam logic [2:0] ACT_PUSH       = 3'd0;
   localparam logic [2:0] ACT_PUSH_FIRST = 3'd1;
   localparam logic [2:0] ACT_GET_DUE    = 3'd2;
   localparam logic [2:0] ACT_REMOVE     = 3'd3;
   localparam logic [2:0] ACT_PEEK       = 3'd4;

   localparam logic [1:0] ST_OK    = 2'd0;
   localparam logic [1:0] ST_FULL  = 2'd1;
   localparam logic [1:0] ST_EMPTY = 2'd2;

   typedef struct packed {
      logic [TIME_BITS-1:0]   time_val;
      logic [HANDLE_BITS-1:0] task_val;
      logic [CLASS_BITS-1:0]  class_val;
   } entry_type;

endpackage

// ===== rtl/core/deadline_ordered_task_queue.sv =====
// Channel | Direction | Handshake          | Payload
// req_    | in        | req_valid/req_stall | action, due_time, now_time, task_id, class_id
// rsp_    | out       | rsp_valid/rsp_stall | task_valid .. status
//
// One item at a time. Peek and a get-due that does not pop read the head entry
// and return a result; push scans entries from the head, then moves each later
// entry up by one; push-first, a popping get-due and remove-class pass over the
// store entry by entry, each entry read from the registered entry memory first.
// Reset empties the store at once through the entry count; no clearing pass.
// A result is held while rsp_stall is high and no item is taken until it is transferred.
module deadline_ordered_task_queue
   import dotq_pkg::*;
(
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_stall,
   input  logic [2:0]             req_action,
   input  logic [TIME_BITS-1:0]   req_due_time,
   input  logic [TIME_BITS-1:0]   req_now_time,
   input  logic [HANDLE_BITS-1:0] req_task_id,
   input  logic [CLASS_BITS-1:0]  req_class_id,
   output logic                   rsp_valid,
   input  logic                   rsp_stall,
   output logic                   rsp_task_valid,
   output logic [HANDLE_BITS-1:0] rsp_out_task_id,
   output logic [TIME_BITS-1:0]   rsp_wait_time,
   output logic [TIME_BITS-1:0]   rsp_earliest_time,
   output logic [6:0]             rsp_removed_count,
   output logic [1:0]             rsp_status
);

   typedef enum logic [3:0] {
      S_IDLE, S_HEAD_RD, S_HEAD_USE, S_SCAN_RD, S_SCAN_CHK,
      S_SHIFT_RD, S_SHIFT_WR, S_PUT, S_REM_RD, S_REM_CHK, S_DONE
   } state_type;

   state_type               state_ff;
   logic [2:0]              act_ff;
   logic [TIME_BITS-1:0]    due_ff, now_ff;
   logic [HANDLE_BITS-1:0]  task_ff;
   logic [CLASS_BITS-1:0]   class_ff;
   logic [CNT_BITS-1:0]     count_ff;
   logic [CNT_BITS-1:0]     pos_ff;   // scan / insert position, read index
   logic [CNT_BITS-1:0]     wpos_ff;  // shift cursor or compaction write index
   logic [6:0]              rem_ff;
   logic                    wr_en;
   logic [IDX_BITS-1:0]     wr_addr, rd_addr;
   entry_type               wr_data, rd_data, new_ff;
   logic                    rsp_valid_ff, tv_ff;
   logic [HANDLE_BITS-1:0]  otask_ff;
   logic [TIME_BITS-1:0]    wait_ff, early_ff;
   logic [1:0]              status_ff;

   dotq_ram u_ram (
      .clock  (clock),
      .wr_en  (wr_en),
      .wr_addr(wr_addr),
      .wr_data(wr_data),
      .rd_addr(rd_addr),
      .rd_data(rd_data)
   );

   assign req_stall = (state_ff != S_IDLE) || rsp_valid_ff;

   always_comb begin
      wr_en   = 1'b0;
      wr_addr = wpos_ff[IDX_BITS-1:0];
      wr_data = rd_data;
      rd_addr = pos_ff[IDX_BITS-1:0];
      case (state_ff)
         S_SHIFT_RD: rd_addr = IDX_BITS'(wpos_ff - CNT_BITS'(1));
         S_SHIFT_WR: begin
            wr_en = 1'b1;
         end
         S_PUT: begin
            wr_en   = 1'b1;
            wr_addr = pos_ff[IDX_BITS-1:0];
            wr_data = new_ff;
         end
         S_REM_CHK: wr_en = (rd_data.class_val != class_ff) || (act_ff == ACT_GET_DUE);
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (rsp_valid_ff && !rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
         case (state_ff)
            S_IDLE: begin
               if (req_valid && !req_stall) begin
                  act_ff    <= req_action;
                  due_ff    <= req_due_time;
                  now_ff    <= req_now_time;
                  task_ff   <= req_task_id;
                  class_ff  <= req_class_id;
                  tv_ff     <= 1'b0;
                  otask_ff  <= '0;
                  wait_ff   <= '0;
                  early_ff  <= '0;
                  rem_ff    <= '0;
                  status_ff <= ST_OK;
                  pos_ff    <= '0;
                  wpos_ff   <= '0;
                  state_ff  <= S_DONE;
                  case (req_action)
                     ACT_PUSH, ACT_PUSH_FIRST: begin
                        if (count_ff == CNT_BITS'(QUEUE_DEPTH)) begin
                           status_ff <= ST_FULL;
                        end else if (count_ff == '0) begin
                           new_ff   <= '{req_action == ACT_PUSH ? req_due_time
                                                                : req_now_time,
                                         req_task_id, req_class_id};
                           state_ff <= S_PUT;
                        end else if (req_action == ACT_PUSH) begin
                           new_ff   <= '{req_due_time, req_task_id, req_class_id};
                           state_ff <= S_SCAN_RD;
                        end else begin
                           state_ff <= S_HEAD_RD;
                        end
                     end
                     ACT_GET_DUE: begin
                        if (count_ff == '0) begin
                           wait_ff   <= '1;
                           status_ff <= ST_EMPTY;
                        end else begin
                           state_ff <= S_HEAD_RD;
                        end
                     end
                     ACT_REMOVE: begin
                        if (count_ff == '0) status_ff <= ST_EMPTY;
                        else state_ff <= S_REM_RD;
                     end
                     ACT_PEEK: begin
                        if (count_ff == '0) begin
                           early_ff  <= req_now_time;
                           status_ff <= ST_EMPTY;
                        end else begin
                           state_ff <= S_HEAD_RD;
                        end
                     end
                     default: ;
                  endcase
               end
            end
            S_HEAD_RD: state_ff <= S_HEAD_USE;
            S_HEAD_USE: begin
               state_ff <= S_DONE;
               case (act_ff)
                  ACT_PUSH_FIRST: begin
                     new_ff   <= '{rd_data.time_val == '0 ? '0
                                   : rd_data.time_val - TIME_BITS'(1),
                                   task_ff, class_ff};
                     pos_ff   <= '0;
                     wpos_ff  <= count_ff;
                     state_ff <= S_SHIFT_RD;
                  end
                  ACT_GET_DUE: begin
                     if (rd_data.time_val <= now_ff) begin
                        tv_ff    <= 1'b1;
                        otask_ff <= rd_data.task_val;
                        // Pop is a compaction that drops slot 0.
                        class_ff <= rd_data.class_val;
                        pos_ff   <= CNT_BITS'(1);
                        wpos_ff  <= '0;
                        state_ff <= (count_ff == CNT_BITS'(1)) ? S_DONE : S_REM_RD;
                        if (count_ff == CNT_BITS'(1)) count_ff <= '0;
                     end else begin
                        wait_ff <= rd_data.time_val - now_ff;
                     end
                  end
                  default: early_ff <= rd_data.time_val;
               endcase
            end
            S_SCAN_RD: state_ff <= S_SCAN_CHK;
            S_SCAN_CHK: begin
               if (rd_data.time_val <= new_ff.time_val) begin
                  if (pos_ff + CNT_BITS'(1) == count_ff) begin
                     pos_ff   <= count_ff;
                     state_ff <= S_PUT;
                  end else begin
                     pos_ff   <= pos_ff + CNT_BITS'(1);
                     state_ff <= S_SCAN_RD;
                  end
               end else begin
                  wpos_ff  <= count_ff;
                  state_ff <= S_SHIFT_RD;
               end
            end
            S_SHIFT_RD: state_ff <= (wpos_ff == pos_ff) ? S_PUT : S_SHIFT_WR;
            S_SHIFT_WR: begin
               wpos_ff  <= wpos_ff - CNT_BITS'(1);
               state_ff <= (wpos_ff - CNT_BITS'(1) == pos_ff) ? S_PUT : S_SHIFT_RD;
            end
            S_PUT: begin
               count_ff <= count_ff + CNT_BITS'(1);
               state_ff <= S_DONE;
            end
            S_REM_RD: state_ff <= S_REM_CHK;
            S_REM_CHK: begin
               // A pop copies every remaining entry down by one.
               if (rd_data.class_val != class_ff || act_ff == ACT_GET_DUE) begin
                  wpos_ff <= wpos_ff + CNT_BITS'(1);
               end else if (act_ff == ACT_REMOVE) begin
                  rem_ff <= rem_ff + 7'd1;
               end
               if (pos_ff + CNT_BITS'(1) == count_ff) begin
                  if (act_ff == ACT_REMOVE) begin
                     count_ff <= (rd_data.class_val != class_ff)
                                 ? wpos_ff + CNT_BITS'(1) : wpos_ff;
                  end else begin
                     count_ff <= count_ff - CNT_BITS'(1);
                  end
                  state_ff <= S_DONE;
               end else begin
                  pos_ff   <= pos_ff + CNT_BITS'(1);
                  state_ff <= S_REM_RD;
               end
            end
            S_DONE: begin
               if (!rsp_valid_ff) begin
                  rsp_valid_ff <= 1'b1;
                  state_ff     <= S_IDLE;
               end
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_task_valid    = tv_ff;
   assign rsp_out_task_id   = otask_ff;
   assign rsp_wait_time     = wait_ff;
   assign rsp_earliest_time = early_ff;
   assign rsp_removed_count = rem_ff;
   assign rsp_status        = status_ff;

   assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_BITS'(QUEUE_DEPTH))
      else $error("entry count beyond depth");
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid)
      else $error("result lost under stall");
   assert property (@(posedge clock) disable iff (reset)
      state_ff != S_IDLE |-> req_stall)
      else $error("item taken while busy");
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_task_valid |-> rsp_status == ST_OK)
      else $error("pop with bad status");

endmodule

// ===== rtl/core/dotq_ram.sv =====
module dotq_ram
   import dotq_pkg::*;
(
   input  logic                clock,
   input  logic                wr_en,
   input  logic [IDX_BITS-1:0] wr_addr,
   input  entry_type           wr_data,
   input  logic [IDX_BITS-1:0] rd_addr,
   output entry_type           rd_data
);

   entry_type mem [QUEUE_DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data <= mem[rd_addr];
   end

endmodule
